/* rtl/core/pipa_pkg.sv */
`default_nettype none

package pipa_pkg;

	// query sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} pipa_state_t;

	// request codes on req_type
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// control from the sequencer to the edge unit
	typedef struct packed {
		logic issue;  // a vertex read is issued this cycle
		logic first;  // the read is the closing vertex, used only as the first "previous" one
		logic clear;  // restart both running totals
	} pipa_ctl_t;

	// status from the edge unit back to the sequencer
	typedef struct packed {
		logic busy;   // reads or edge terms still in flight
		logic match;  // |shoelace total| equals triangle total
	} pipa_stat_t;

endpackage

`default_nettype wire

/* rtl/core/pipa_ram.sv */
`default_nettype none

module pipa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pipa_edge.sv */
`default_nettype none

module pipa_edge
	import pipa_pkg::*;
#(
	parameter int COORD_BITS   = 16,
	parameter int MAX_VERTICES = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pipa_ctl_t                      ctl,
	input  wire logic      [2*COORD_BITS-1:0]   rd_data,
	input  wire logic signed [COORD_BITS-1:0]   px,
	input  wire logic signed [COORD_BITS-1:0]   py,
	output pipa_stat_t                          stat
);

	localparam int DW    = COORD_BITS + 1;       // coordinate difference or sum
	localparam int PW    = 2 * COORD_BITS + 2;   // one product
	localparam int TW    = PW + 1;               // difference of two products
	localparam int ACC_W = TW + $clog2(MAX_VERTICES + 1);

	logic                         v_s1, first_s1, v_s2, v_s3;
	logic signed [COORD_BITS-1:0] cur_x, cur_y;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [DW-1:0]         dxi, dyj, dxj, dyi, sum_x, dif_y;
	logic signed [PW-1:0]         pa_s2, pb_s2, sh_s2;
	logic signed [TW-1:0]         t_s3;
	logic signed [PW-1:0]         sh_s3;
	logic signed [ACC_W-1:0]      sh_acc_q;
	logic        [ACC_W-1:0]      tri_acc_q;
	logic        [ACC_W-1:0]      sh_abs;
	logic        [ACC_W-1:0]      t_ext;
	logic                         t_neg;

	// current vertex straight from the memory read register
	assign cur_x = rd_data[COORD_BITS-1:0];
	assign cur_y = rd_data[2*COORD_BITS-1:COORD_BITS];

	// edge operands, one bit wider than a coordinate
	assign dxi   = {cur_x[COORD_BITS-1], cur_x} - {px[COORD_BITS-1], px};
	assign dyj   = {prev_y_q[COORD_BITS-1], prev_y_q} - {py[COORD_BITS-1], py};
	assign dxj   = {prev_x_q[COORD_BITS-1], prev_x_q} - {px[COORD_BITS-1], px};
	assign dyi   = {cur_y[COORD_BITS-1], cur_y} - {py[COORD_BITS-1], py};
	assign sum_x = {prev_x_q[COORD_BITS-1], prev_x_q} + {cur_x[COORD_BITS-1], cur_x};
	assign dif_y = {prev_y_q[COORD_BITS-1], prev_y_q} - {cur_y[COORD_BITS-1], cur_y};

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			v_s1     <= ctl.issue;
			first_s1 <= ctl.first;
			v_s2     <= v_s1 && !first_s1;
			v_s3     <= v_s2;
		end
	end

	// s1 -> s2: three products per edge; the vertex then becomes the previous one
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
			pa_s2    <= dxi * dyj;
			pb_s2    <= dxj * dyi;
			sh_s2    <= sum_x * dif_y;
		end
	end

	// s2 -> s3: signed doubled triangle area
	always_ff @(posedge clk) begin
		if (v_s2) begin
			t_s3  <= {pa_s2[PW-1], pa_s2} - {pb_s2[PW-1], pb_s2};
			sh_s3 <= sh_s2;
		end
	end

	// absolute value folded into the add: invert and carry in when negative
	assign t_neg = t_s3[TW-1];
	assign t_ext = {{(ACC_W-TW){t_neg}}, t_s3} ^ {ACC_W{t_neg}};

	// running totals
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			sh_acc_q  <= '0;
			tri_acc_q <= '0;
		end else if (v_s3) begin
			sh_acc_q  <= sh_acc_q + {{(ACC_W-PW){sh_s3[PW-1]}}, sh_s3};
			tri_acc_q <= tri_acc_q + t_ext + {{(ACC_W-1){1'b0}}, t_neg};
		end
	end

	// final exact compare
	assign sh_abs     = sh_acc_q[ACC_W-1] ? (~sh_acc_q + 1'b1) : sh_acc_q;
	assign stat.match = (sh_abs == tri_acc_q);
	assign stat.busy  = v_s1 || v_s2 || v_s3;

endmodule

`default_nettype wire

/* rtl/core/point_in_polygon_area_test_top.sv */
`default_nettype none

// Convex point-in-polygon test by area sums. Append transfers (req_type 0) store one
// vertex each; first_vertex restarts the list, and vertices past
// MAX_VERTICES are dropped and reported through overflowed. A query transfer
// (req_type 1) gives one result after one pass over the stored vertices: the
// single read port of the vertex memory delivers one vertex a cycle, and the input
// stays stalled for the pass, the drain of the edge pipeline and, while a result
// still waits on the output, that wait. inside_res is 1 when the doubled polygon area
// equals the sum of the doubled triangle areas, compared exactly; the test is only
// meaningful for convex polygons, and an empty list or a single vertex reports
// inside. Appends are taken while a query result still waits on the output.
module point_in_polygon_area_test_top
	import pipa_pkg::*;
#(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic                         first_vertex,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              inside_res,
	output logic                              overflowed
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

	pipa_state_t                  state_q, state_d;
	logic        [CW-1:0]         count_q, iss_q, count_base, rd_idx;
	logic                         drop_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic                         out_valid_q, inside_q, ovf_q;
	logic                         in_acc, app, qry, has_room, wr_en, load_out, out_free;
	logic        [2*COORD_BITS-1:0] rd_data;
	pipa_ctl_t                    ctl;
	pipa_stat_t                   stat;

	assign in_acc     = in_valid && !in_stall;
	assign app        = in_acc && (req_type == REQ_APPEND);
	assign qry        = in_acc && (req_type == REQ_QUERY);
	assign count_base = first_vertex ? '0 : count_q;
	assign has_room   = count_base < MAX_CNT;
	assign out_free   = !out_valid_q || !out_stall;

	// the closing vertex is read first, then vertices 0 .. n-1
	assign rd_idx = (iss_q == '0) ? (count_q - 1'b1) : (iss_q - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (qry) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_READ;
				end
			end
			ST_READ: begin
				if (iss_q == count_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer; writes and reads never share a cycle
	always_comb begin
		in_stall  = 1'b1;
		ctl       = '0;
		wr_en     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				wr_en     = app && has_room;
				ctl.clear = qry;
			end
			ST_READ: begin
				ctl.issue = 1'b1;
				ctl.first = (iss_q == '0);
			end
			ST_DRAIN: begin
				ctl = '0;
			end
			ST_FINISH: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			iss_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (app) begin
				count_q <= has_room ? (count_base + 1'b1) : count_base;
				if (first_vertex) begin
					drop_q <= 1'b0;
				end else if (!has_room) begin
					drop_q <= 1'b1;
				end
			end
			if (qry) begin
				iss_q <= '0;
			end else if (state_q == ST_READ) begin
				iss_q <= iss_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// test point and result payload
	always_ff @(posedge clk) begin
		if (qry) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (load_out) begin
			inside_q <= stat.match;
			ovf_q    <= drop_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;
	assign overflowed = ovf_q;

	// vertex store, y in the upper half
	pipa_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_VERTICES)
	) u_vertex_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_base[AW-1:0]),
		.wr_data ({coord_y, coord_x}),
		.rd_en   (ctl.issue),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_data (rd_data)
	);

	// per-edge arithmetic and running totals
	pipa_edge #(
		.COORD_BITS  (COORD_BITS),
		.MAX_VERTICES(MAX_VERTICES)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_data(rd_data),
		.px     (px_q),
		.py     (py_q),
		.stat   (stat)
	);

`ifndef NO_ASSERTIONS
	// memory is never written during a pass
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && ctl.issue))
		else $error("vertex write during a read pass");

	// list never grows past capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("vertex count beyond capacity");

	// a vertex is dropped only on a full list
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (count_q == MAX_CNT))
		else $error("drop flag set on a list with room");

	// a result is presented only after the finish state
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	// pass counter stays within the list
	a_iss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (iss_q <= count_q))
		else $error("read pass past end of list");
`endif

endmodule

`default_nettype wire
